>>> rtl/gtv_pkg.sv
package gtv_pkg;

  // Field widths
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned CMD_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Quarter-wave sine table
  localparam int unsigned GTV_SINE_DEPTH = 256;
  localparam logic [63:0] PI_HALF_Q30    = 64'd1686629713;

  // Register reset values
  localparam logic [15:0]        RST_GAIN_FWD    = 16'd3277;
  localparam logic [15:0]        RST_GAIN_LAT    = 16'd3277;
  localparam logic [15:0]        RST_INV_WB      = 16'd19140;
  localparam logic [14:0]        RST_SPEED_UPPER = 15'd410;
  localparam logic signed [15:0] RST_SPEED_LOWER = -16'sd307;
  localparam logic [14:0]        RST_STEER_LIMIT = 15'd205;
  localparam logic [14:0]        RST_RADIUS      = 15'd1229;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_FWD    = 3'd0,
    CFG_GAIN_LAT    = 3'd1,
    CFG_INV_WB      = 3'd2,
    CFG_SPEED_UPPER = 3'd3,
    CFG_SPEED_LOWER = 3'd4,
    CFG_STEER_LIMIT = 3'd5,
    CFG_RADIUS      = 3'd6
  } cfg_idx_e;

  // Input action codes
  localparam logic ACT_GOAL = 1'b0;
  localparam logic ACT_ODOM = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_GX,     // x*x
    S_GY,     // y*y
    S_GR,     // r*r
    S_GC,     // radius compare
    S_RS,     // sine lookup, x error product
    S_RC,     // cosine lookup, y error product
    S_V0,     // cos*ex
    S_V1,     // sin*ey
    S_W0,     // cos*ey
    S_W1,     // sin*ex, speed saturate
    S_W2,     // lateral difference
    S_W3,     // low part * inv_wheelbase
    S_W4,     // high part * inv_wheelbase
    S_W5,     // steer accumulate
    S_DONE    // steer saturate, output load
  } state_e;

endpackage

>>> rtl/gtv_in_if.sv
interface gtv_in_if;
  import gtv_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic [ANGLE_W-1:0]        heading;

  modport source (output valid, action, target_x, target_y, heading, input ready);
  modport sink   (input valid, action, target_x, target_y, heading, output ready);

endinterface

>>> rtl/gtv_out_if.sv
interface gtv_out_if;
  import gtv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] speed_cmd;
  logic signed [CMD_W-1:0] steer_cmd;

  modport source (output valid, speed_cmd, steer_cmd, input ready);
  modport sink   (input valid, speed_cmd, steer_cmd, output ready);

endinterface

>>> rtl/goal_tracking_velocity_steer_controller_top.sv
// Channel | Dir | Beat payload                           | Handshake
// in_i    | in  | action, target_x, target_y, heading    | valid/ready
// out_o   | out | speed_cmd, steer_cmd                   | valid/ready
// cfg     | in  | cfg_idx_i, cfg_data_i                  | cfg_we_i, no stall
//
// Goal beat: accept, three products on the shared 34x17 multiplier, then the
// radius compare. Odometry beat with a pending, unreached goal: accept, eight
// products, the lateral difference, the steer sum, load. Odometry beat with
// nothing to emit: accepted while the block stays idle. Reset restores register
// defaults and clears goal state; no clearing pass. A waiting result does not
// block input; only the final load stalls on a full output register.
module goal_tracking_velocity_steer_controller_top #(
  parameter int unsigned SINE_TABLE_DEPTH = gtv_pkg::GTV_SINE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gtv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gtv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  gtv_in_if.sink                         in_i,
  gtv_out_if.source                      out_o
);
  import gtv_pkg::*;

  localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned PW = 14 + IW;

  // Table entry i = sin(pi*i/(2*D)) in Q2.14, Q30 Taylor series, elaboration only
  function automatic logic [14:0] sin_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x    = (PI_HALF_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = '0;
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 1) sum = sum - $signed(term);
      else            sum = sum + $signed(term);
      t = (term * x2) >> 30;
      case (k)
        0:       term = t / 64'd6;
        1:       term = t / 64'd20;
        2:       term = t / 64'd42;
        3:       term = t / 64'd72;
        4:       term = t / 64'd110;
        5:       term = t / 64'd156;
        6:       term = t / 64'd210;
        default: term = t / 64'd272;
      endcase
    end
    if (sum < 0) sum = '0;
    r = (sum + 64'sd32768) >>> 16;
    if (r > 64'sd16384) r = 64'sd16384;
    return r[14:0];
  endfunction

  // Table address for a turn value: quadrant folding, no interpolation
  function automatic logic [IW-1:0] rom_addr(input logic [ANGLE_W-1:0] turn);
    logic [PW-1:0] pd;
    logic [IW-1:0] idx;
    pd  = PW'(turn[13:0]) * PW'(SINE_TABLE_DEPTH);
    idx = pd[PW-1:14];
    return turn[14] ? (IW'(SINE_TABLE_DEPTH) - idx) : idx;
  endfunction

  // Sine ROM
  logic [14:0] sin_rom [0:SINE_TABLE_DEPTH];
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [14:0] Entry = sin_entry(g);
    assign sin_rom[g] = Entry;
  end

  // Configuration registers
  logic [15:0]        gain_fwd_q, gain_lat_q, inv_wb_q;
  logic [14:0]        speed_upper_q, steer_limit_q, radius_q;
  logic signed [15:0] speed_lower_q;
  cfg_idx_e           cfg_sel;

  assign cfg_sel = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_fwd_q    <= RST_GAIN_FWD;
      gain_lat_q    <= RST_GAIN_LAT;
      inv_wb_q      <= RST_INV_WB;
      speed_upper_q <= RST_SPEED_UPPER;
      speed_lower_q <= RST_SPEED_LOWER;
      steer_limit_q <= RST_STEER_LIMIT;
      radius_q      <= RST_RADIUS;
    end else if (cfg_we_i) begin
      case (cfg_sel)
        CFG_GAIN_FWD:    gain_fwd_q    <= cfg_data_i;
        CFG_GAIN_LAT:    gain_lat_q    <= cfg_data_i;
        CFG_INV_WB:      inv_wb_q      <= cfg_data_i;
        CFG_SPEED_UPPER: speed_upper_q <= cfg_data_i[14:0];
        CFG_SPEED_LOWER: speed_lower_q <= $signed(cfg_data_i);
        CFG_STEER_LIMIT: steer_limit_q <= cfg_data_i[14:0];
        CFG_RADIUS:      radius_q      <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // State and datapath registers
  state_e             state_q, state_d;
  logic               goal_pending_q, goal_pending_d;
  logic               goal_reached_q, goal_reached_d;
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] goal_fwd_q, goal_lat_q;
  logic [15:0]        hd_q;
  logic [14:0]        rom_q;
  logic signed [50:0] prod_q;
  logic signed [32:0] ex_q, ey_q;
  logic signed [16:0] sin_q, cos_q;
  logic signed [63:0] acc_q;
  logic signed [47:0] dacc_q;
  logic signed [15:0] speed_q;
  logic signed [15:0] out_speed_q, out_steer_q;

  logic               in_ready, in_fire, out_load;
  logic [IW-1:0]      addr;
  logic [15:0]        cos_turn;
  logic signed [16:0] rom_s, rom_sin, rom_cos;
  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] prod_d;

  assign in_ready   = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign cos_turn = hd_q + 16'h4000;
  assign rom_s    = $signed({2'b00, rom_q});
  assign rom_sin  = hd_q[15] ? -rom_s : rom_s;
  assign rom_cos  = cos_turn[15] ? -rom_s : rom_s;

  // Table address select
  always_comb begin
    case (state_q)
      S_RC:    addr = rom_addr(cos_turn);
      default: addr = rom_addr(hd_q);
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    case (state_q)
      S_GX: begin
        mul_a = 34'(goal_fwd_q);
        mul_b = 17'(goal_fwd_q);
      end
      S_GY: begin
        mul_a = 34'(goal_lat_q);
        mul_b = 17'(goal_lat_q);
      end
      S_GR: begin
        mul_a = $signed({19'd0, radius_q});
        mul_b = $signed({2'b00, radius_q});
      end
      S_RS: begin
        mul_a = 34'(goal_fwd_q);
        mul_b = $signed({1'b0, gain_fwd_q});
      end
      S_RC: begin
        mul_a = 34'(goal_lat_q);
        mul_b = $signed({1'b0, gain_lat_q});
      end
      S_V0: begin
        mul_a = 34'(ex_q);
        mul_b = rom_cos;
      end
      S_V1: begin
        mul_a = 34'(ey_q);
        mul_b = sin_q;
      end
      S_W0: begin
        mul_a = 34'(ey_q);
        mul_b = cos_q;
      end
      S_W1: begin
        mul_a = 34'(ex_q);
        mul_b = sin_q;
      end
      S_W3: begin
        mul_a = $signed({8'd0, dacc_q[25:0]});
        mul_b = $signed({1'b0, inv_wb_q});
      end
      S_W4: begin
        mul_a = 34'($signed(dacc_q[47:26]));
        mul_b = $signed({1'b0, inv_wb_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Speed: round Q38 to Q10 (ties up), then saturate, upper limit first
  logic signed [63:0] spd_sum;
  logic signed [35:0] spd_rnd, spd_hi, spd_lo;
  logic signed [15:0] spd_sat;

  assign spd_sum = acc_q + (64'sd1 <<< 27);
  assign spd_rnd = spd_sum[63:28];
  assign spd_hi  = $signed({21'd0, speed_upper_q});
  assign spd_lo  = 36'(speed_lower_q);

  always_comb begin
    if (spd_rnd > spd_hi)      spd_sat = spd_hi[15:0];
    else if (spd_rnd < spd_lo) spd_sat = spd_lo[15:0];
    else                       spd_sat = spd_rnd[15:0];
  end

  // Steer: round Q50 to Q10, then symmetric saturate
  logic signed [63:0] str_sum;
  logic signed [23:0] str_rnd, str_hi, str_lo;
  logic signed [15:0] str_sat;

  assign str_sum = acc_q + (64'sd1 <<< 39);
  assign str_rnd = str_sum[63:40];
  assign str_hi  = $signed({9'd0, steer_limit_q});
  assign str_lo  = -str_hi;

  always_comb begin
    if (str_rnd > str_hi)      str_sat = str_hi[15:0];
    else if (str_rnd < str_lo) str_sat = str_lo[15:0];
    else                       str_sat = str_rnd[15:0];
  end

  // Next state and control
  always_comb begin
    state_d        = state_q;
    goal_pending_d = goal_pending_q;
    goal_reached_d = goal_reached_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_load       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.action == ACT_GOAL) begin
            goal_pending_d = 1'b1;
            state_d        = S_GX;
          end else if (goal_pending_q && !goal_reached_q) begin
            goal_pending_d = 1'b0;
            state_d        = S_RS;
          end
        end
      end
      S_GX: state_d = S_GY;
      S_GY: state_d = S_GR;
      S_GR: state_d = S_GC;
      S_GC: begin
        goal_reached_d = (acc_q <= 64'(prod_q));
        state_d        = S_IDLE;
      end
      S_RS: state_d = S_RC;
      S_RC: state_d = S_V0;
      S_V0: state_d = S_V1;
      S_V1: state_d = S_W0;
      S_W0: state_d = S_W1;
      S_W1: state_d = S_W2;
      S_W2: state_d = S_W3;
      S_W3: state_d = S_W4;
      S_W4: state_d = S_W5;
      S_W5: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      goal_pending_q <= 1'b0;
      goal_reached_q <= 1'b0;
      out_valid_q    <= 1'b0;
      goal_fwd_q     <= '0;
      goal_lat_q     <= '0;
    end else begin
      state_q        <= state_d;
      goal_pending_q <= goal_pending_d;
      goal_reached_q <= goal_reached_d;
      out_valid_q    <= out_valid_d;
      if (in_fire && in_i.action == ACT_GOAL) begin
        goal_fwd_q <= in_i.target_x;
        goal_lat_q <= in_i.target_y;
      end
    end
  end

  // Datapath: product register, accumulators, ROM read
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rom_q  <= sin_rom[addr];
    if (in_fire) hd_q <= in_i.heading;
    case (state_q)
      S_GY: acc_q <= 64'(prod_q);
      S_GR: acc_q <= acc_q + 64'(prod_q);
      S_RC: begin
        sin_q <= rom_sin;
        ex_q  <= prod_q[32:0];
      end
      S_V0: begin
        cos_q <= rom_cos;
        ey_q  <= prod_q[32:0];
      end
      S_V1: acc_q <= 64'(prod_q);
      S_W0: acc_q <= acc_q + 64'(prod_q);
      S_W1: begin
        dacc_q  <= $signed(prod_q[47:0]);
        speed_q <= spd_sat;
      end
      S_W2: dacc_q <= dacc_q - $signed(prod_q[47:0]);
      S_W4: acc_q  <= 64'(prod_q);
      S_W5: acc_q  <= acc_q + (64'(prod_q) <<< 26);
      default: ;
    endcase
    if (out_load) begin
      out_speed_q <= speed_q;
      out_steer_q <= str_sat;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.speed_cmd = out_speed_q;
  assign out_o.steer_cmd = out_steer_q;

  // Checks
  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("output beat raised outside final step");

  a_pending_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> !goal_pending_q)
    else $error("goal still pending while a command is produced");

  a_idle_odom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.action == ACT_ODOM && !(goal_pending_q && !goal_reached_q))
      |=> state_q == S_IDLE)
    else $error("odometry beat without active goal started work");

  a_goal_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.action == ACT_GOAL) |=> (state_q == S_GX && goal_pending_q))
    else $error("goal beat did not start radius check");

endmodule

>>> tb/sv/goal_tracking_velocity_steer_controller_top_tb.sv
`timescale 1ns / 1ps

module goal_tracking_velocity_steer_controller_top_tb;
  import gtv_pkg::*;

  localparam int SINE_D      = GTV_SINE_DEPTH;
  localparam int SETTLE_CYC  = 16;      // covers the odometry schedule
  localparam int DRAIN_GUARD = 5000;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CMD_W-1:0] speed;
    logic signed [CMD_W-1:0] steer;
  } motion_cmd_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gtv_in_if  in_if ();
  gtv_out_if out_if ();

  goal_tracking_velocity_steer_controller_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Shadow copy of the registers and goal state
  int  m_gain_fwd    = int'(RST_GAIN_FWD);
  int  m_gain_lat    = int'(RST_GAIN_LAT);
  int  m_inv_wb      = int'(RST_INV_WB);
  int  m_speed_upper = int'(RST_SPEED_UPPER);
  int  m_speed_lower = int'(RST_SPEED_LOWER);
  int  m_steer_limit = int'(RST_STEER_LIMIT);
  int  m_radius      = int'(RST_RADIUS);
  int  goal_fwd      = 0;
  int  goal_lat      = 0;
  bit  goal_pending  = 1'b0;
  bit  goal_reached  = 1'b0;

  longint      sine_tab [0:SINE_D];
  motion_cmd_t expected_cmds [$];

  bit idle_en = 1'b1;
  int n_sent, n_goals, n_odom, n_cmds, n_settings, n_fail;
  int cycle_count;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("** goal_tracking_velocity_steer_controller_top: FAILED **");
      $finish;
    end
  end

  // Result side back-pressure
  initial begin
    forever begin
      @(negedge clk_i);
      out_if.ready <= !idle_en || ($urandom_range(99) >= 28);
    end
  end

  // Quarter-wave sine table, Q2.14, from a Q30 Taylor series
  function automatic void build_sine_table();
    longint unsigned x, x2, term;
    longint          sum, r;
    for (int i = 0; i <= SINE_D; i++) begin
      x    = (PI_HALF_Q30 * i) / SINE_D;
      x2   = (x * x) >> 30;
      term = x;
      sum  = 0;
      for (int k = 0; k < 8; k++) begin
        if (k % 2 == 1) sum -= longint'(term);
        else            sum += longint'(term);
        term = ((term * x2) >> 30) / ((2 * k + 2) * (2 * k + 3));
      end
      if (sum < 0) sum = 0;
      r = (sum + 32768) >>> 16;
      if (r > 16384) r = 16384;
      sine_tab[i] = r;
    end
  endfunction

  function automatic longint sine_turn(input logic [ANGLE_W-1:0] turn);
    int     idx;
    longint v;
    idx = (int'(turn[13:0]) * SINE_D) >> 14;
    v   = turn[14] ? sine_tab[SINE_D - idx] : sine_tab[idx];
    return turn[15] ? -v : v;
  endfunction

  // Shift down to Q10, ties toward plus infinity
  function automatic longint round_q10(input longint v, input int s);
    longint unsigned half;
    half = 64'd1 << (s - 1);
    if (v >= 0) return longint'(($unsigned(v) + half) >> s);
    return -longint'(($unsigned(-v) + half - 1) >> s);
  endfunction

  // Expected behavior for one accepted beat
  task automatic predict_motion_cmd(input logic act, input logic signed [COORD_W-1:0] tx,
                                    input logic signed [COORD_W-1:0] ty,
                                    input logic [ANGLE_W-1:0] hd);
    longint      s, c, ex, ey, vq, wq, v, w, rr;
    motion_cmd_t cmd;
    if (act == ACT_GOAL) begin
      n_goals++;
      goal_fwd     = int'(tx);
      goal_lat     = int'(ty);
      rr           = longint'(m_radius);
      goal_pending = 1'b1;
      goal_reached = (longint'(goal_fwd) * goal_fwd + longint'(goal_lat) * goal_lat) <= rr * rr;
    end else begin
      n_odom++;
      if (goal_pending && !goal_reached) begin
        s  = sine_turn(hd);
        c  = sine_turn(hd + 16'h4000);
        ex = longint'(goal_fwd) * m_gain_fwd;
        ey = longint'(goal_lat) * m_gain_lat;
        vq = c * ex + s * ey;
        wq = (c * ey - s * ex) * m_inv_wb;
        v  = round_q10(vq, 28);
        w  = round_q10(wq, 40);
        // upper limit wins when the two limits meet
        if (v > m_speed_upper)      v = longint'(m_speed_upper);
        else if (v < m_speed_lower) v = longint'(m_speed_lower);
        if (w > m_steer_limit)       w = longint'(m_steer_limit);
        else if (w < -m_steer_limit) w = -longint'(m_steer_limit);
        cmd.speed = v[15:0];
        cmd.steer = w[15:0];
        expected_cmds.push_back(cmd);
        goal_pending = 1'b0;
      end
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_results
    motion_cmd_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected motion command speed %0d steer %0d", $time,
                 out_if.speed_cmd, out_if.steer_cmd);
        n_fail++;
      end else begin
        want = expected_cmds.pop_front();
        n_cmds++;
        if (out_if.speed_cmd !== want.speed) begin
          $display("%0t: speed_cmd mismatch: expected %0d, got %0d", $time,
                   want.speed, out_if.speed_cmd);
          n_fail++;
        end
        if (out_if.steer_cmd !== want.steer) begin
          $display("%0t: steer_cmd mismatch: expected %0d, got %0d", $time,
                   want.steer, out_if.steer_cmd);
          n_fail++;
        end
      end
    end
  end

  // One input beat; called at a falling edge, returns at a falling edge
  task automatic send_item(input logic act, input logic signed [COORD_W-1:0] tx,
                           input logic signed [COORD_W-1:0] ty,
                           input logic [ANGLE_W-1:0] hd);
    while (idle_en && $urandom_range(99) < 28) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.target_x <= tx;
    in_if.target_y <= ty;
    in_if.heading  <= hd;
    do @(posedge clk_i); while (!in_if.ready);
    predict_motion_cmd(act, tx, ty, hd);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Hold the sender until every expected command is back
  task automatic wait_for_results();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_cmds.size() != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk_i);
      guard++;
    end
    if (expected_cmds.size() != 0) begin
      $display("%0t: %0d expected motion commands never arrived", $time, expected_cmds.size());
      n_fail++;
      expected_cmds.delete();
    end
  endtask

  // Idle block: no results owed and any goal beat finished
  task automatic quiesce();
    wait_for_results();
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_GAIN_FWD:    m_gain_fwd    = int'(val);
      CFG_GAIN_LAT:    m_gain_lat    = int'(val);
      CFG_INV_WB:      m_inv_wb      = int'(val);
      CFG_SPEED_UPPER: m_speed_upper = int'(val[14:0]);
      CFG_SPEED_LOWER: m_speed_lower = int'($signed(val));
      CFG_STEER_LIMIT: m_steer_limit = int'(val[14:0]);
      CFG_RADIUS:      m_radius      = int'(val[14:0]);
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [15:0] gf, input logic [15:0] gl,
                                input logic [15:0] iw, input logic [15:0] su,
                                input logic [15:0] sl, input logic [15:0] st,
                                input logic [15:0] ar);
    write_reg(CFG_GAIN_FWD, gf);
    write_reg(CFG_GAIN_LAT, gl);
    write_reg(CFG_INV_WB, iw);
    write_reg(CFG_SPEED_UPPER, su);
    write_reg(CFG_SPEED_LOWER, sl);
    write_reg(CFG_STEER_LIMIT, st);
    write_reg(CFG_RADIUS, ar);
    n_settings++;
  endtask

  // Full-range offsets some of the time, otherwise a random span
  task automatic pick_target(output logic signed [COORD_W-1:0] tx,
                             output logic signed [COORD_W-1:0] ty);
    int lim;
    if ($urandom_range(99) < 40) begin
      tx = 16'($urandom);
      ty = 16'($urandom);
    end else begin
      lim = $urandom_range(64, 32767);
      tx  = 16'(int'($urandom_range(0, 2 * lim)) - lim);
      ty  = 16'(int'($urandom_range(0, 2 * lim)) - lim);
    end
  endtask

  task automatic send_odom();
    send_item(ACT_ODOM, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Mostly goal-then-odometry sequences, some noise and overwritten goals
  task automatic run_tracking_mix(input int n_items);
    int                        start, pick, r;
    logic signed [COORD_W-1:0] tx, ty;
    start = n_sent;
    while (n_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        pick_target(tx, ty);
        send_item(ACT_GOAL, tx, ty, 16'($urandom));
        repeat ($urandom_range(1, 2)) send_odom();
      end else if (pick < 85) begin
        send_odom();
      end else if (pick < 95) begin
        // goal inside the radius
        r  = m_radius / 2;
        tx = 16'($urandom_range(0, r));
        ty = 16'($urandom_range(0, r));
        if ($urandom_range(1)) tx = -tx;
        if ($urandom_range(1)) ty = -ty;
        send_item(ACT_GOAL, tx, ty, 16'($urandom));
        send_odom();
      end else begin
        pick_target(tx, ty);
        send_item(ACT_GOAL, tx, ty, 16'($urandom));
        pick_target(tx, ty);
        send_item(ACT_GOAL, tx, ty, 16'($urandom));
        send_odom();
      end
      if ($urandom_range(99) < 3) wait_for_results();
    end
  endtask

  // Reset register values: pending, cleared, reached and boundary goals
  task automatic test_directed_defaults();
    send_item(ACT_ODOM, 16'sd0, 16'sd0, 16'd0);
    send_item(ACT_GOAL, 16'sd2048, 16'sd1024, 16'd0);
    send_item(ACT_ODOM, 16'sd0, 16'sd0, 16'd0);
    send_item(ACT_ODOM, 16'sd0, 16'sd0, 16'd0);
    send_item(ACT_GOAL, 16'sd300, -16'sd200, 16'd0);
    send_item(ACT_ODOM, 16'sd0, 16'sd0, 16'd8192);
    // exactly on the radius counts as reached
    send_item(ACT_GOAL, 16'sd1229, 16'sd0, 16'd0);
    send_item(ACT_ODOM, 16'sd0, 16'sd0, 16'd0);
    send_item(ACT_GOAL, 16'sd0, 16'sd1230, 16'd0);
    send_item(ACT_ODOM, 16'sd0, 16'sd0, 16'd16384);
    send_item(ACT_GOAL, 16'sd32767, -16'sd32768, 16'hFFFF);
    send_item(ACT_ODOM, 16'sh7FFF, 16'sh7FFF, 16'd32768);
    send_item(ACT_GOAL, -16'sd32768, 16'sd32767, 16'd0);
    send_item(ACT_ODOM, -16'sd1, -16'sd1, 16'hFFFF);
    quiesce();
  endtask

  // Register extremes: widest limits and zero radius, then all zero but the largest radius
  task automatic test_directed_extremes();
    write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000);
    send_item(ACT_GOAL, 16'sd0, 16'sd0, 16'd0);
    send_item(ACT_ODOM, 16'sd0, 16'sd0, 16'd0);
    send_item(ACT_GOAL, 16'sd1, 16'sd0, 16'd0);
    send_item(ACT_ODOM, 16'sd0, 16'sd0, 16'd0);
    send_item(ACT_GOAL, -16'sd32768, -16'sd32768, 16'd0);
    send_item(ACT_ODOM, 16'sd0, 16'sd0, 16'd24576);
    quiesce();
    write_all_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    send_item(ACT_GOAL, 16'sd32767, 16'sd0, 16'd0);
    send_item(ACT_ODOM, 16'sd0, 16'sd0, 16'd0);
    send_item(ACT_GOAL, -16'sd32768, 16'sd0, 16'd0);
    send_item(ACT_ODOM, 16'sd0, 16'sd0, 16'd16384);
    quiesce();
  endtask

  // Several random register settings, the last one back at reset values
  task automatic test_random_tracking();
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        write_all_regs(RST_GAIN_FWD, RST_GAIN_LAT, RST_INV_WB, 16'(RST_SPEED_UPPER),
                       RST_SPEED_LOWER, 16'(RST_STEER_LIMIT), 16'(RST_RADIUS));
      end else begin
        write_all_regs(
          16'($urandom_range(0, 1) ? $urandom_range(0, 8192) : $urandom_range(0, 65535)),
          16'($urandom_range(0, 1) ? $urandom_range(0, 8192) : $urandom_range(0, 65535)),
          16'($urandom_range(0, 65535)),
          16'($urandom_range(0, 1) ? $urandom_range(0, 4096) : $urandom_range(0, 32767)),
          16'(-int'($urandom_range(0, 32768))),
          16'($urandom_range(0, 1) ? $urandom_range(0, 4096) : $urandom_range(0, 32767)),
          16'($urandom_range(0, 3000)));
      end
      run_tracking_mix(150);
      quiesce();
    end
  endtask

  // No idling on either side
  task automatic test_back_to_back();
    idle_en = 1'b0;
    run_tracking_mix(120);
    quiesce();
    idle_en = 1'b1;
  endtask

  // Sender holds after each sequence until the commands are back
  task automatic test_drain_pause();
    logic signed [COORD_W-1:0] tx, ty;
    repeat (10) begin
      pick_target(tx, ty);
      send_item(ACT_GOAL, tx, ty, 16'($urandom));
      send_odom();
      send_odom();
      wait_for_results();
    end
    quiesce();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.action   = ACT_GOAL;
    in_if.target_x = '0;
    in_if.target_y = '0;
    in_if.heading  = '0;
    out_if.ready   = 1'b0;
    n_settings     = 1;
    build_sine_table();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_defaults();
    test_directed_extremes();
    test_random_tracking();
    test_back_to_back();
    test_drain_pause();
    quiesce();

    $display("Sent %0d goal and %0d odometry beats across %0d register settings,",
             n_goals, n_odom, n_settings);
    $display("with random stalls, a no-stall burst and drain pauses; %0d commands checked.",
             n_cmds);
    if (n_fail == 0) begin
      $display("** goal_tracking_velocity_steer_controller_top: PASSED **");
    end else begin
      $display("** goal_tracking_velocity_steer_controller_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/gtv_pkg.sv
rtl/gtv_in_if.sv
rtl/gtv_out_if.sv
rtl/goal_tracking_velocity_steer_controller_top.sv
tb/sv/goal_tracking_velocity_steer_controller_top_tb.sv
